/* design/erpc_pkg.sv */
// Shared constants, codes and types of the echelon rope profile checker.
package erpc_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int MAX_ROWS  = 4096;

	localparam int PIX_W = 8;
	localparam int LEN_W = 13;
	localparam int ROW_W = 12;
	localparam int CNT_W = 4;
	localparam int EQ_W  = 3;
	localparam int IDX_W = 2;

	localparam logic [LEN_W-1:0] WIDTH_CAP  = LEN_W'((MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH);
	localparam logic [ROW_W-1:0] ROW_CAP    =
		ROW_W'(((MAX_ROWS - 1) > 4095) ? 4095 : (MAX_ROWS - 1));
	localparam logic [LEN_W-1:0] ECH_CAP    = {LEN_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_CAP    = {CNT_W{1'b1}};
	localparam logic [EQ_W-1:0]  FLAT_AFTER = EQ_W'(3);

	typedef enum logic [IDX_W-1:0] {
		REG_FG_VALUE,
		REG_MIN_ROWS,
		REG_MAX_ECHELONS
	} reg_idx_t;

	typedef enum logic [1:0] {
		TREND_NONE,
		TREND_GROW,
		TREND_SHRINK,
		TREND_FLAT
	} trend_t;

	// Row summary from the run measurement
	typedef struct packed {
		logic             has_rope;
		logic [LEN_W-1:0] len;
	} row_sum_t;

	// One result request
	typedef struct packed {
		logic             row_has_rope;
		logic [LEN_W-1:0] rope_length;
		trend_t           trend;
		logic [CNT_W-1:0] echelon_count;
		logic [ROW_W-1:0] first_echelon_row;
		logic             has_first_echelon;
		logic             violation;
		logic             frame_done;
		logic             frame_ok;
	} result_t;

endpackage

/* design/erpc_if.sv */
// Channel interfaces: pixel input, result output and register writes.
interface erpc_pix_if;
	logic                       valid;
	logic                       ready;
	logic [erpc_pkg::PIX_W-1:0] pixel;
	logic                       row_end;
	logic                       frame_end;

	modport source (output valid, pixel, row_end, frame_end, input ready);
	modport sink   (input valid, pixel, row_end, frame_end, output ready);
endinterface

interface erpc_res_if;
	logic                       valid;
	logic                       ready;
	logic                       row_has_rope;
	logic [erpc_pkg::LEN_W-1:0] rope_length;
	logic [1:0]                 trend;
	logic [erpc_pkg::CNT_W-1:0] echelon_count;
	logic [erpc_pkg::ROW_W-1:0] first_echelon_row;
	logic                       has_first_echelon;
	logic                       violation;
	logic                       frame_done;
	logic                       frame_ok;

	modport source (output valid, row_has_rope, rope_length, trend, echelon_count,
		first_echelon_row, has_first_echelon, violation, frame_done, frame_ok,
		input ready);
	modport sink   (input valid, row_has_rope, rope_length, trend, echelon_count,
		first_echelon_row, has_first_echelon, violation, frame_done, frame_ok,
		output ready);
endinterface

interface erpc_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [erpc_pkg::IDX_W-1:0] index;
	logic [erpc_pkg::LEN_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* design/erpc_run.sv */
// Per-row foreground run measurement.
module erpc_run (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [erpc_pkg::PIX_W-1:0] fg_value,
	input  logic [erpc_pkg::PIX_W-1:0] pixel,
	input  logic                       step,
	input  logic                       row_done,
	output erpc_pkg::row_sum_t         sum
);

	logic                       begun_q, ended_q, broken_q;
	logic [erpc_pkg::LEN_W-1:0] count_q;
	logic                       begun_n, ended_n, broken_n;
	logic [erpc_pkg::LEN_W-1:0] count_n;

	// Fold the current pixel into the run state
	always_comb begin
		begun_n  = begun_q;
		ended_n  = ended_q;
		broken_n = broken_q;
		count_n  = count_q;
		if (pixel == fg_value) begin
			if (ended_q) begin
				broken_n = 1'b1;
			end else begin
				begun_n = 1'b1;
				if (count_q < erpc_pkg::WIDTH_CAP)
					count_n = count_q + 1'b1;
			end
		end else if (begun_q) begin
			ended_n = 1'b1;
		end
		sum.has_rope = begun_n && !broken_n;
		sum.len      = sum.has_rope ? count_n : '0;
	end

	// Advance per pixel, clear at row end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begun_q  <= 1'b0;
			ended_q  <= 1'b0;
			broken_q <= 1'b0;
			count_q  <= '0;
		end else if (step) begin
			if (row_done) begin
				begun_q  <= 1'b0;
				ended_q  <= 1'b0;
				broken_q <= 1'b0;
				count_q  <= '0;
			end else begin
				begun_q  <= begun_n;
				ended_q  <= ended_n;
				broken_q <= broken_n;
				count_q  <= count_n;
			end
		end
	end

endmodule

/* design/echelon_rope_profile_checker.sv */
// Top level: input register, run measurement, echelon profile and result register.
// Takes one pixel per cycle while not stalled, in raster order, and gives one result per row
// end or frame end. Each pixel is held in the input register and is folded into the row state
// there; a row-end or frame-end pixel also loads the result register as it leaves the input
// register. The only stall is such an end pixel meeting a full result register that is not
// being taken that cycle. Register writes are taken in every cycle and apply at once; write
// them only while the block is idle. There is no clearing pass after reset.
module echelon_rope_profile_checker (
	input  logic         clk,
	input  logic         arst_n,
	erpc_cfg_if.sink     cfg,
	erpc_pix_if.sink     px,
	erpc_res_if.source   res
);

	// Configuration registers
	logic [erpc_pkg::PIX_W-1:0] fg_value_q;
	logic [erpc_pkg::LEN_W-1:0] min_rows_q;
	logic [erpc_pkg::CNT_W-1:0] max_ech_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_value_q <= '0;
			min_rows_q <= erpc_pkg::LEN_W'(8);
			max_ech_q  <= erpc_pkg::CNT_W'(3);
		end else if (cfg.valid) begin
			case (cfg.index)
				erpc_pkg::REG_FG_VALUE:     fg_value_q <= cfg.data[erpc_pkg::PIX_W-1:0];
				erpc_pkg::REG_MIN_ROWS:     min_rows_q <= cfg.data;
				erpc_pkg::REG_MAX_ECHELONS: max_ech_q  <= cfg.data[erpc_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	logic                       v_s1;
	logic [erpc_pkg::PIX_W-1:0] pixel_s1;
	logic                       row_end_s1, frame_end_s1;
	logic                       end_s1, adv_s1, out_free;
	logic                       out_v_q;
	erpc_pkg::result_t          out_q;

	assign end_s1   = row_end_s1 || frame_end_s1;
	assign out_free = !out_v_q || res.ready;
	assign adv_s1   = v_s1 && (!end_s1 || out_free);
	assign px.ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (px.ready)
			v_s1 <= px.valid;
	end

	always_ff @(posedge clk) begin
		if (px.ready && px.valid) begin
			pixel_s1     <= px.pixel;
			row_end_s1   <= px.row_end;
			frame_end_s1 <= px.frame_end;
		end
	end

	// Run measurement
	erpc_pkg::row_sum_t sum;

	erpc_run u_run (
		.clk      (clk),
		.arst_n   (arst_n),
		.fg_value (fg_value_q),
		.pixel    (pixel_s1),
		.step     (adv_s1),
		.row_done (end_s1),
		.sum      (sum)
	);

	// Profile state
	logic                       prev_valid_q, prev_valid_n;
	logic [erpc_pkg::LEN_W-1:0] prev_len_q, prev_len_n;
	erpc_pkg::trend_t           trend_q, trend_n;
	logic [erpc_pkg::EQ_W-1:0]  equal_q, equal_n;
	logic [erpc_pkg::LEN_W-1:0] ech_rows_q, ech_rows_n;
	logic [erpc_pkg::CNT_W-1:0] count_q, count_n;
	logic [erpc_pkg::ROW_W-1:0] first_row_q, first_row_n;
	logic                       first_seen_q, first_seen_n;
	logic [erpc_pkg::ROW_W-1:0] row_cnt_q;
	logic                       broken_q, broken_n;
	logic [erpc_pkg::LEN_W-1:0] need;
	logic                       proceed, trend_ok;
	erpc_pkg::result_t          res_n;

	assign need = (min_rows_q == '0) ? erpc_pkg::LEN_W'(1) : min_rows_q;

	// Apply one finished row to the echelon profile
	always_comb begin
		prev_valid_n = prev_valid_q;
		prev_len_n   = prev_len_q;
		trend_n      = trend_q;
		equal_n      = equal_q;
		ech_rows_n   = ech_rows_q;
		count_n      = count_q;
		first_row_n  = first_row_q;
		first_seen_n = first_seen_q;
		broken_n     = broken_q;
		proceed      = 1'b0;
		trend_ok     = 1'b0;
		if (!broken_q) begin
			if (sum.has_rope) begin
				proceed = 1'b1;
				if (!prev_valid_q) begin
					if (!first_seen_q) begin
						first_seen_n = 1'b1;
						first_row_n  = row_cnt_q;
					end
					prev_valid_n = 1'b1;
					equal_n      = '0;
					trend_n      = erpc_pkg::TREND_NONE;
					ech_rows_n   = '0;
				end else if (trend_q == erpc_pkg::TREND_NONE) begin
					if (sum.len > prev_len_q) begin
						trend_n = erpc_pkg::TREND_GROW;
					end else if (sum.len < prev_len_q) begin
						trend_n = erpc_pkg::TREND_SHRINK;
					end else begin
						equal_n = equal_q + 1'b1;
						if (equal_n > erpc_pkg::FLAT_AFTER)
							trend_n = erpc_pkg::TREND_FLAT;
					end
				end else begin
					trend_ok = (trend_q == erpc_pkg::TREND_GROW && sum.len >= prev_len_q)
						|| (trend_q == erpc_pkg::TREND_SHRINK && sum.len <= prev_len_q)
						|| (trend_q == erpc_pkg::TREND_FLAT && sum.len == prev_len_q);
					if (!trend_ok) begin
						broken_n = 1'b1;
						proceed  = 1'b0;
					end
				end
				if (proceed) begin
					if (ech_rows_n < erpc_pkg::ECH_CAP) begin
						ech_rows_n = ech_rows_n + 1'b1;
						if (ech_rows_n == need && count_q < erpc_pkg::CNT_CAP)
							count_n = count_q + 1'b1;
					end
					prev_len_n = sum.len;
				end
			end else begin
				prev_valid_n = 1'b0;
			end
		end

		res_n.row_has_rope      = sum.has_rope;
		res_n.rope_length       = sum.len;
		res_n.trend             = trend_n;
		res_n.echelon_count     = count_n;
		res_n.first_echelon_row = first_row_n;
		res_n.has_first_echelon = first_seen_n;
		res_n.violation         = broken_n;
		res_n.frame_done        = frame_end_s1;
		res_n.frame_ok          = frame_end_s1 && !broken_n && (count_n != '0)
			&& (count_n <= max_ech_q);
	end

	// Hold profile state between row ends, clear at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			prev_len_q   <= '0;
			trend_q      <= erpc_pkg::TREND_NONE;
			equal_q      <= '0;
			ech_rows_q   <= '0;
			count_q      <= '0;
			first_row_q  <= '0;
			first_seen_q <= 1'b0;
			row_cnt_q    <= '0;
			broken_q     <= 1'b0;
		end else if (adv_s1 && end_s1) begin
			if (frame_end_s1) begin
				prev_valid_q <= 1'b0;
				prev_len_q   <= '0;
				trend_q      <= erpc_pkg::TREND_NONE;
				equal_q      <= '0;
				ech_rows_q   <= '0;
				count_q      <= '0;
				first_row_q  <= '0;
				first_seen_q <= 1'b0;
				row_cnt_q    <= '0;
				broken_q     <= 1'b0;
			end else begin
				prev_valid_q <= prev_valid_n;
				prev_len_q   <= prev_len_n;
				trend_q      <= trend_n;
				equal_q      <= equal_n;
				ech_rows_q   <= ech_rows_n;
				count_q      <= count_n;
				first_row_q  <= first_row_n;
				first_seen_q <= first_seen_n;
				broken_q     <= broken_n;
				if (row_cnt_q < erpc_pkg::ROW_CAP)
					row_cnt_q <= row_cnt_q + 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (adv_s1 && end_s1)
			out_v_q <= 1'b1;
		else if (res.ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && end_s1)
			out_q <= res_n;
	end

	assign res.valid             = out_v_q;
	assign res.row_has_rope      = out_q.row_has_rope;
	assign res.rope_length       = out_q.rope_length;
	assign res.trend             = out_q.trend;
	assign res.echelon_count     = out_q.echelon_count;
	assign res.first_echelon_row = out_q.first_echelon_row;
	assign res.has_first_echelon = out_q.has_first_echelon;
	assign res.violation         = out_q.violation;
	assign res.frame_done        = out_q.frame_done;
	assign res.frame_ok          = out_q.frame_ok;

	// Violation stays set until the frame ends
	a_broken_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		broken_q && !(adv_s1 && frame_end_s1) |=> broken_q)
		else $error("violation flag dropped inside a frame");

	// A counted echelon implies a recorded first echelon
	a_count_first: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 |-> first_seen_q)
		else $error("echelon counted without a first echelon row");

	// Flat trend only after enough equal rows
	a_flat_equal: assert property (@(posedge clk) disable iff (!arst_n)
		trend_q == erpc_pkg::TREND_FLAT |-> equal_q > erpc_pkg::FLAT_AFTER)
		else $error("flat trend without enough equal rows");

	// Mid-row pixels never stall
	a_no_midrow_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !end_s1 |-> adv_s1)
		else $error("mid-row pixel stalled");

	// A pass verdict only comes on a clean frame end
	a_ok_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.frame_ok |-> out_q.frame_done && !out_q.violation)
		else $error("frame_ok outside a clean frame end");

endmodule

/* tb/sv/echelon_rope_profile_checker_test.sv */
// Testbench for the echelon rope profile checker: pixel stimulus, row result prediction, checks.
module echelon_rope_profile_checker_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;

	erpc_cfg_if cfg_ch ();
	erpc_pix_if px_ch ();
	erpc_res_if res_ch ();

	echelon_rope_profile_checker i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.px     (px_ch),
		.res    (res_ch)
	);

	// Register copies
	logic [erpc_pkg::PIX_W-1:0] fg_cfg  = '0;
	logic [erpc_pkg::LEN_W-1:0] min_cfg = erpc_pkg::LEN_W'(8);
	logic [erpc_pkg::CNT_W-1:0] max_cfg = erpc_pkg::CNT_W'(3);

	// Row measurement copies
	logic                       seg_open, seg_closed, seg_split;
	logic [erpc_pkg::LEN_W-1:0] seg_len;
	// Echelon profile copies
	logic                       prof_live;
	logic [erpc_pkg::LEN_W-1:0] last_len;
	erpc_pkg::trend_t           cur_trend;
	logic [erpc_pkg::EQ_W-1:0]  same_rows;
	logic [erpc_pkg::LEN_W-1:0] ech_len;
	logic [erpc_pkg::CNT_W-1:0] ech_total;
	logic [erpc_pkg::ROW_W-1:0] start_row;
	logic                       start_seen;
	logic [erpc_pkg::ROW_W-1:0] row_idx;
	logic                       trend_broken;

	erpc_pkg::result_t          row_results[$];
	logic [erpc_pkg::PIX_W-1:0] line_px[$];
	int                         fail_count = 0;
	int                         px_sent = 0;
	bit                         src_calm = 1'b0;
	bit                         sink_calm = 1'b0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold the run to a fixed ceiling
	initial begin
		#60_000_000;
		$display("simulation failed");
		$finish;
	end

	// Pick an idle span: mostly none or short, a few long
	function automatic int idle_span(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Stall the result channel at random
	initial begin
		int hold;
		hold = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else begin
				hold = idle_span(sink_calm);
				res_ch.ready <= (hold == 0);
				if (hold > 0)
					hold--;
			end
		end
	end

	task automatic clear_profile();
		seg_open = 1'b0; seg_closed = 1'b0; seg_split = 1'b0; seg_len = '0;
		prof_live = 1'b0; last_len = '0; cur_trend = erpc_pkg::TREND_NONE; same_rows = '0;
		ech_len = '0; ech_total = '0; start_row = '0; start_seen = 1'b0;
		row_idx = '0; trend_broken = 1'b0;
	endtask

	// Fold one accepted pixel into the row and profile state; queue a result at row end
	task automatic model_pixel(input logic [erpc_pkg::PIX_W-1:0] p, input logic re,
		input logic fe);
		erpc_pkg::result_t          r;
		logic                       rope, holds;
		logic [erpc_pkg::LEN_W-1:0] len, need;
		if (p == fg_cfg) begin
			if (seg_closed)
				seg_split = 1'b1;
			else begin
				seg_open = 1'b1;
				if (seg_len < erpc_pkg::WIDTH_CAP)
					seg_len++;
			end
		end else if (seg_open) begin
			seg_closed = 1'b1;
		end
		if (!re && !fe)
			return;

		rope = seg_open && !seg_split;
		len  = rope ? seg_len : '0;
		need = (min_cfg == 0) ? erpc_pkg::LEN_W'(1) : min_cfg;

		// Update the echelon profile unless the trend is already broken
		if (!trend_broken && !rope) begin
			prof_live = 1'b0;
		end else if (!trend_broken) begin
			holds = 1'b1;
			if (!prof_live) begin
				if (!start_seen) begin
					start_seen = 1'b1;
					start_row  = row_idx;
				end
				prof_live = 1'b1;
				same_rows = '0;
				cur_trend = erpc_pkg::TREND_NONE;
				ech_len   = '0;
			end else if (cur_trend == erpc_pkg::TREND_NONE) begin
				if (len > last_len)
					cur_trend = erpc_pkg::TREND_GROW;
				else if (len < last_len)
					cur_trend = erpc_pkg::TREND_SHRINK;
				else begin
					same_rows = same_rows + 1'b1;
					if (same_rows > erpc_pkg::FLAT_AFTER)
						cur_trend = erpc_pkg::TREND_FLAT;
				end
			end else begin
				holds = (cur_trend == erpc_pkg::TREND_GROW && len >= last_len)
					|| (cur_trend == erpc_pkg::TREND_SHRINK && len <= last_len)
					|| (cur_trend == erpc_pkg::TREND_FLAT && len == last_len);
			end
			if (!holds) begin
				trend_broken = 1'b1;
			end else begin
				if (ech_len < erpc_pkg::ECH_CAP) begin
					ech_len++;
					if (ech_len == need && ech_total < erpc_pkg::CNT_CAP)
						ech_total++;
				end
				last_len = len;
			end
		end

		r.row_has_rope      = rope;
		r.rope_length       = len;
		r.trend             = cur_trend;
		r.echelon_count     = ech_total;
		r.first_echelon_row = start_row;
		r.has_first_echelon = start_seen;
		r.violation         = trend_broken;
		r.frame_done        = fe;
		r.frame_ok          = fe && !trend_broken && ech_total != 0 && ech_total <= max_cfg;
		row_results = {row_results, r};

		seg_open = 1'b0; seg_closed = 1'b0; seg_split = 1'b0; seg_len = '0;
		if (row_idx < erpc_pkg::ROW_CAP)
			row_idx++;
		if (fe)
			clear_profile();
	endtask

	task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 60)
				$display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// Check each taken result against the oldest pending row
	always @(posedge clk) begin
		erpc_pkg::result_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready) begin
			if (row_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 60)
					$display("%0t ns: result expected none actual one", $time);
			end else begin
				want = row_results.pop_front();
				cmp_field("row_has_rope", want.row_has_rope, res_ch.row_has_rope);
				cmp_field("rope_length", want.rope_length, res_ch.rope_length);
				cmp_field("trend", want.trend, res_ch.trend);
				cmp_field("echelon_count", want.echelon_count, res_ch.echelon_count);
				cmp_field("first_echelon_row", want.first_echelon_row,
					res_ch.first_echelon_row);
				cmp_field("has_first_echelon", want.has_first_echelon,
					res_ch.has_first_echelon);
				cmp_field("violation", want.violation, res_ch.violation);
				cmp_field("frame_done", want.frame_done, res_ch.frame_done);
				cmp_field("frame_ok", want.frame_ok, res_ch.frame_ok);
			end
		end
	end

	// Send one pixel request and wait until it is taken
	task automatic send_pixel(input logic [erpc_pkg::PIX_W-1:0] p, input logic re,
		input logic fe);
		int gap;
		gap = idle_span(src_calm);
		@(negedge clk);
		if (gap > 0) begin
			px_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		px_ch.valid     <= 1'b1;
		px_ch.pixel     <= p;
		px_ch.row_end   <= re;
		px_ch.frame_end <= fe;
		@(posedge clk);
		while (!px_ch.ready)
			@(posedge clk);
		px_sent++;
		model_pixel(p, re, fe);
	endtask

	task automatic put_fg(input int n);
		repeat (n) line_px = {line_px, fg_cfg};
	endtask

	// Push background pixels of any value but the foreground one
	task automatic put_bg(input int n);
		repeat (n) line_px = {line_px, fg_cfg ^ erpc_pkg::PIX_W'($urandom_range(1, 255))};
	endtask

	// Send the built row, marking its last pixel
	task automatic send_line(input bit fe, input bit re);
		bit tail;
		for (int i = 0; i < line_px.size(); i++) begin
			tail = (i == line_px.size() - 1);
			send_pixel(line_px[i], tail && re, tail && fe);
		end
		line_px.delete();
	endtask

	task automatic send_rope(input int lead, input int run, input int trail, input bit fe,
		input bit re);
		put_bg(lead);
		put_fg(run);
		put_bg(trail);
		send_line(fe, re);
	endtask

	// Drop the pixel channel and let every pending row come out
	task automatic wait_idle();
		@(negedge clk);
		px_ch.valid <= 1'b0;
		while (row_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input erpc_pkg::reg_idx_t idx,
		input logic [erpc_pkg::LEN_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			erpc_pkg::REG_FG_VALUE:     fg_cfg = val[erpc_pkg::PIX_W-1:0];
			erpc_pkg::REG_MIN_ROWS:     min_cfg = val;
			erpc_pkg::REG_MAX_ECHELONS: max_cfg = val[erpc_pkg::CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [erpc_pkg::PIX_W-1:0] fg,
		input logic [erpc_pkg::LEN_W-1:0] minr, input logic [erpc_pkg::CNT_W-1:0] maxe);
		write_reg(erpc_pkg::REG_FG_VALUE, erpc_pkg::LEN_W'(fg));
		write_reg(erpc_pkg::REG_MIN_ROWS, minr);
		write_reg(erpc_pkg::REG_MAX_ECHELONS, erpc_pkg::LEN_W'(maxe));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Growing, split and blank rows, frame end alone, then a trend break
	task automatic test_trend_rules();
		wait_idle();
		set_regs(8'h00, 13'd2, 4'd1);
		send_rope(0, 1, 1, 0, 1);
		send_rope(1, 3, 0, 0, 1);
		send_rope(0, 3, 2, 0, 1);
		put_fg(2); put_bg(1); put_fg(1); send_line(0, 1);
		put_bg(3); send_line(0, 1);
		send_rope(2, 2, 0, 0, 1);
		send_rope(0, 2, 0, 1, 0);
		send_rope(0, 1, 0, 0, 1);
		send_rope(0, 4, 1, 0, 1);
		send_rope(1, 2, 0, 0, 1);
		send_rope(0, 5, 0, 0, 1);
		put_bg(2); send_line(1, 1);
	endtask

	// Flat echelons under zero minimum and zero maximum, then a passing frame
	task automatic test_flat_and_zero_regs();
		wait_idle();
		set_regs(8'hFF, 13'd0, 4'd0);
		repeat (5) send_rope(1, 2, 1, 0, 1);
		send_rope(0, 3, 0, 0, 1);
		send_rope(0, 2, 0, 1, 1);
		wait_idle();
		set_regs(8'hFF, 13'd1, 4'd1);
		send_rope(0, 1, 0, 0, 1);
		send_rope(0, 1, 0, 1, 1);
	endtask

	// Run length saturates at the width cap
	task automatic test_long_run();
		wait_idle();
		set_regs(8'h80, 13'd1, 4'd14);
		send_rope(2, 4100, 1, 0, 1);
		send_rope(0, 4095, 0, 1, 1);
	endtask

	// Row counter and echelon length saturate in one tall frame
	task automatic test_tall_frame();
		wait_idle();
		set_regs(8'h3C, 13'd8191, 4'd15);
		repeat (4100) begin
			put_bg(1);
			send_line(0, 1);
		end
		repeat (8199) send_rope(0, 1, 0, 0, 1);
		send_rope(0, 1, 0, 1, 1);
	endtask

	// Echelon count saturates at its cap
	task automatic test_count_cap();
		wait_idle();
		set_regs(8'h01, 13'd1, 4'd15);
		for (int i = 0; i < 18; i++) begin
			send_rope(0, $urandom_range(1, 3), 1, 0, 1);
			put_bg(1);
			send_line(i == 17, 1);
		end
	endtask

	// Build one frame mostly of trend-following echelons, with blank, split and noise rows
	task automatic send_random_frame();
		int rows, r, pick, ramp, span_left, len;
		bit fin;
		rows = $urandom_range(3, 24);
		r = 0;
		span_left = 0;
		ramp = 0;
		len = 1;
		src_calm  = ($urandom_range(0, 4) == 0);
		sink_calm = ($urandom_range(0, 4) == 0);
		while (r < rows) begin
			r++;
			fin = (r == rows);
			pick = (span_left > 0) ? 0 : $urandom_range(0, 9);
			if (span_left > 0) begin
				// Advance the rope length along the echelon trend
				span_left--;
				case (ramp)
					0: len = len + $urandom_range(0, 2);
					1: if (len > 2) len = len - $urandom_range(0, 2);
					2: ;
					default: len = $urandom_range(1, 8);
				endcase
				if ($urandom_range(0, 15) == 0)
					len = (ramp == 0 && len > 1) ? len - 1 : len + 1;
				send_rope($urandom_range(0, 2), len, $urandom_range(0, 2), fin,
					!fin || ($urandom_range(0, 5) != 0));
			end else if (pick < 7) begin
				// Start a new echelon
				ramp = $urandom_range(0, 3);
				span_left = $urandom_range(0, 8);
				len = (ramp == 1) ? $urandom_range(6, 14) : $urandom_range(1, 6);
				send_rope($urandom_range(0, 2), len, $urandom_range(0, 2), fin,
					!fin || ($urandom_range(0, 5) != 0));
			end else begin
				if (pick == 7) begin
					put_bg($urandom_range(1, 6));
				end else if (pick == 8) begin
					put_bg($urandom_range(0, 2)); put_fg($urandom_range(1, 4));
					put_bg($urandom_range(1, 3)); put_fg($urandom_range(1, 4));
					put_bg($urandom_range(0, 2));
				end else begin
					repeat ($urandom_range(1, 12)) begin
						if ($urandom_range(0, 1))
							put_fg(1);
						else
							put_bg(1);
					end
				end
				send_line(fin, !fin || ($urandom_range(0, 5) != 0));
			end
		end
	endtask

	// Random frames under changing register settings
	task automatic test_random_frames();
		int goal, frames, m, f;
		goal = px_sent + 1250;
		frames = 0;
		while (px_sent < goal) begin
			if (frames % 3 == 0) begin
				wait_idle();
				f = $urandom_range(0, 3);
				m = $urandom_range(0, 15);
				set_regs((f == 0) ? 8'h00 : (f == 1) ? 8'hFF
						: erpc_pkg::PIX_W'($urandom_range(0, 255)),
					(m == 15) ? erpc_pkg::LEN_W'($urandom_range(16, 8191))
						: erpc_pkg::LEN_W'(m % 7),
					erpc_pkg::CNT_W'($urandom_range(0, 15)));
			end
			send_random_frame();
			frames++;
		end
		src_calm  = 1'b0;
		sink_calm = 1'b0;
	endtask

	// Reset, run each test, drain and report
	initial begin
		arst_n             = 1'b0;
		px_ch.valid        = 1'b0;
		px_ch.pixel        = '0;
		px_ch.row_end      = 1'b0;
		px_ch.frame_end    = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = erpc_pkg::REG_FG_VALUE;
		cfg_ch.data        = '0;
		clear_profile();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_trend_rules();
		test_flat_and_zero_regs();
		test_long_run();
		test_tall_frame();
		test_count_cap();
		test_random_frames();

		wait_idle();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
